[hw/rtl/mtfs_pkg.sv]
package mtfs_pkg;

    // Result status codes
    typedef enum logic [1:0] {
        ST_SEARCH = 2'd0,
        ST_FLUSH  = 2'd1,
        ST_ABORT  = 2'd2
    } mtfs_status_t;

    // MBAP header walk: transaction id, protocol id, length, unit id, function code
    typedef enum logic [7:0] {
        PH_TID_HI = 8'b0000_0001,
        PH_TID_LO = 8'b0000_0010,
        PH_PID_HI = 8'b0000_0100,
        PH_PID_LO = 8'b0000_1000,
        PH_LEN_HI = 8'b0001_0000,
        PH_LEN_LO = 8'b0010_0000,
        PH_UNIT   = 8'b0100_0000,
        PH_FUNC   = 8'b1000_0000
    } mtfs_phase_t;

    localparam int unsigned LIMIT_W  = 24;
    localparam int unsigned SEGLEN_W = 16;
    localparam int unsigned OFFS_W   = 17;
    // byte counter only needs to tell apart values up to the largest limit
    localparam int unsigned CNT_W    = LIMIT_W + 1;

    localparam logic [7:0]         LEN_MIN         = 8'd2;
    localparam logic [7:0]         LEN_MAX         = 8'd254;
    localparam logic [7:0]         CLIENT_FC_LIMIT = 8'h80;
    localparam logic [7:0]         FC_NONE         = 8'h00;
    localparam logic [LIMIT_W-1:0] ABORT_LIMIT_RST = 24'd65536;
    localparam logic [CNT_W-1:0]   CNT_SAT         = {1'b1, {LIMIT_W{1'b0}}};

    typedef struct packed {
        logic [7:0]          data_byte;
        logic                from_client;
        logic [SEGLEN_W-1:0] segment_length;
        logic                last_in_segment;
    } mtfs_item_t;

    typedef struct packed {
        mtfs_status_t      status;
        logic [OFFS_W-1:0] flush_offset;
        logic              bad_length;
    } mtfs_result_t;

endpackage

[hw/rtl/mtfs_intf.sv]
interface mtfs_byte_if
    import mtfs_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [7:0]          data_byte;
    logic                from_client;
    logic [SEGLEN_W-1:0] segment_length;
    logic                last_in_segment;

    modport source (output valid, data_byte, from_client, segment_length, last_in_segment,
                    input ready);
    modport sink   (input valid, data_byte, from_client, segment_length, last_in_segment,
                    output ready);
endinterface

interface mtfs_result_if
    import mtfs_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [1:0]        status;
    logic [OFFS_W-1:0] flush_offset;
    logic              bad_length;

    modport source (output valid, status, flush_offset, bad_length, input ready);
    modport sink   (input valid, status, flush_offset, bad_length, output ready);
endinterface

interface mtfs_cfg_if
    import mtfs_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [LIMIT_W-1:0] abort_limit;

    modport source (output valid, abort_limit, input ready);
    modport sink   (input valid, abort_limit, output ready);
endinterface

[hw/rtl/modbus_tcp_frame_splitter.sv]
// Modbus/TCP MBAP header deframer.
// stream: one TCP payload byte per beat with direction, segment length and
//   end-of-segment mark. result: at most one beat per input byte giving
//   search, flush (with the segment offset past the frame end) or abort.
// cfg: writes abort_limit; ready is always high, write only while idle.
// Path: an accepted byte waits in the input register until the result register has
//   room; its result beat, if any, is then registered there.
// Throughput: one byte per cycle while no result is held. Each byte needs only
//   the header state update, one 25-bit saturating add and one compare against
//   abort_limit, all between the input register and the result register.
// Once a header is flushed, the frame body bytes are skipped without results.
// Reset: header walk restarts at the transaction id, counters clear,
//   abort_limit returns to 65536, both stages empty.
// Stall: a held result blocks further processing; the input register then
//   fills and stream.ready drops. Nothing is lost or repeated.
module modbus_tcp_frame_splitter
    import mtfs_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    mtfs_byte_if.sink      stream,
    mtfs_result_if.source  result,
    mtfs_cfg_if.sink       cfg
);

    logic         item_valid;
    mtfs_item_t   item;
    logic         res_valid;
    mtfs_result_t res;
    logic         room;
    logic         step;

    // a byte is processed when the result register can take its beat
    assign step = item_valid && room;

    mtfs_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .stream     (stream),
        .step       (step),
        .item_valid (item_valid),
        .item       (item)
    );

    mtfs_hdr_core u_hdr_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .step      (step),
        .item      (item),
        .res_valid (res_valid),
        .res       (res)
    );

    mtfs_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .res_valid (res_valid),
        .res       (res),
        .room      (room),
        .result    (result)
    );

endmodule

[hw/rtl/mtfs_in_stage.sv]
module mtfs_in_stage
    import mtfs_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    mtfs_byte_if.sink        stream,
    input  logic             step,
    output logic             item_valid,
    output mtfs_item_t       item
);

    logic       valid_reg;
    logic       valid_next;
    mtfs_item_t item_reg;
    logic       take;

    // room when empty or when the held beat moves on this cycle
    assign stream.ready = !valid_reg || step;
    assign take         = stream.valid && stream.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (step)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload capture
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg.data_byte       <= stream.data_byte;
            item_reg.from_client     <= stream.from_client;
            item_reg.segment_length  <= stream.segment_length;
            item_reg.last_in_segment <= stream.last_in_segment;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

[hw/rtl/mtfs_hdr_core.sv]
module mtfs_hdr_core
    import mtfs_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    mtfs_cfg_if.sink     cfg,
    input  logic         step,
    input  mtfs_item_t   item,
    output logic         res_valid,
    output mtfs_result_t res
);

    logic [LIMIT_W-1:0]  abort_limit_reg;
    mtfs_phase_t         phase_reg, phase_next;
    logic                len_hi_nz_reg, len_hi_nz_next;
    logic [7:0]          frame_len_reg, frame_len_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [SEGLEN_W-1:0] seg_off_reg, seg_off_next;
    logic [7:0]          skip_reg, skip_next;
    logic                drop_reg, drop_next;

    logic                parsed;
    logic                invalid;
    logic                bad_len;
    logic                flush;
    logic [SEGLEN_W-1:0] add_amt;
    logic [CNT_W:0]      cnt_sum;
    logic [CNT_W-1:0]    cnt_add;
    logic [7:0]          b;

    assign cfg.ready = 1'b1;
    assign b         = item.data_byte;
    assign parsed    = !drop_reg && (skip_reg == 8'd0);

    // saturating add of the unframed byte count
    always_comb
    begin
        if (invalid)
        begin
            add_amt = (item.segment_length > seg_off_reg) ?
                      (item.segment_length - seg_off_reg) : SEGLEN_W'(1);
        end
        else
        begin
            add_amt = SEGLEN_W'(1);
        end
        cnt_sum = {1'b0, cnt_reg} + (CNT_W + 1)'(add_amt);
        cnt_add = (cnt_sum[CNT_W:LIMIT_W] != '0) ? CNT_SAT : cnt_sum[CNT_W-1:0];
    end

    // header walk
    always_comb
    begin
        phase_next     = phase_reg;
        len_hi_nz_next = len_hi_nz_reg;
        frame_len_next = frame_len_reg;
        cnt_next       = cnt_reg;
        skip_next      = skip_reg;
        invalid        = 1'b0;
        bad_len        = 1'b0;
        flush          = 1'b0;

        if (drop_reg)
        begin
            skip_next = skip_reg;
        end
        else if (skip_reg != 8'd0)
        begin
            skip_next = skip_reg - 8'd1;
        end
        else
        begin
            case (phase_reg)
                PH_TID_HI: phase_next = PH_TID_LO;
                PH_TID_LO: phase_next = PH_PID_HI;
                PH_PID_HI: phase_next = PH_PID_LO;
                PH_PID_LO: phase_next = PH_LEN_HI;
                PH_LEN_HI:
                begin
                    len_hi_nz_next = (b != 8'd0);
                    phase_next     = PH_LEN_LO;
                end
                PH_LEN_LO:
                begin
                    if (len_hi_nz_reg || (b < LEN_MIN) || (b > LEN_MAX))
                    begin
                        invalid = 1'b1;
                        bad_len = 1'b1;
                    end
                    else
                    begin
                        frame_len_next = b;
                        phase_next     = PH_UNIT;
                    end
                end
                PH_UNIT:   phase_next = PH_FUNC;
                PH_FUNC:
                begin
                    if ((b == FC_NONE) || (item.from_client && (b >= CLIENT_FC_LIMIT)))
                    begin
                        invalid = 1'b1;
                    end
                    else
                    begin
                        flush      = 1'b1;
                        skip_next  = frame_len_reg - LEN_MIN;
                        phase_next = PH_TID_HI;
                    end
                end
                default:   phase_next = PH_TID_LO;
            endcase

            if (flush)
            begin
                cnt_next = '0;
            end
            else
            begin
                cnt_next = cnt_add;
            end

            if (invalid)
            begin
                phase_next     = PH_TID_HI;
                len_hi_nz_next = 1'b0;
            end
        end
    end

    // segment bookkeeping
    always_comb
    begin
        if (item.last_in_segment)
        begin
            seg_off_next = '0;
            drop_next    = 1'b0;
        end
        else
        begin
            seg_off_next = seg_off_reg + SEGLEN_W'(1);
            drop_next    = drop_reg || invalid;
        end
    end

    // result of this beat
    always_comb
    begin
        res.status       = ST_SEARCH;
        res.flush_offset = '0;
        res.bad_length   = 1'b0;
        if (invalid)
        begin
            res.status     = (cnt_add >= {1'b0, abort_limit_reg}) ? ST_ABORT : ST_SEARCH;
            res.bad_length = bad_len;
        end
        else if (flush)
        begin
            res.status       = ST_FLUSH;
            res.flush_offset = {1'b0, seg_off_reg} + OFFS_W'(frame_len_reg) - OFFS_W'(1);
        end
        res_valid = invalid || flush || (item.last_in_segment && parsed);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            abort_limit_reg <= ABORT_LIMIT_RST;
            phase_reg       <= PH_TID_HI;
            len_hi_nz_reg   <= 1'b0;
            frame_len_reg   <= '0;
            cnt_reg         <= '0;
            seg_off_reg     <= '0;
            skip_reg        <= '0;
            drop_reg        <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                abort_limit_reg <= cfg.abort_limit;
            end
            if (step)
            begin
                phase_reg     <= phase_next;
                len_hi_nz_reg <= len_hi_nz_next;
                frame_len_reg <= frame_len_next;
                cnt_reg       <= cnt_next;
                seg_off_reg   <= seg_off_next;
                skip_reg      <= skip_next;
                drop_reg      <= drop_next;
            end
        end
    end

endmodule

[hw/rtl/mtfs_out_stage.sv]
module mtfs_out_stage
    import mtfs_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         step,
    input  logic         res_valid,
    input  mtfs_result_t res,
    output logic         room,
    mtfs_result_if.source result
);

    logic         valid_reg;
    logic         valid_next;
    mtfs_result_t res_reg;
    logic         load;

    assign room = !valid_reg || result.ready;
    assign load = step && res_valid;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

    assign result.valid        = valid_reg;
    assign result.status       = res_reg.status;
    assign result.flush_offset = res_reg.flush_offset;
    assign result.bad_length   = res_reg.bad_length;

endmodule

[sim/tb.sv]
`timescale 1ns / 100ps

module tb;
    import mtfs_pkg::*;

    localparam int N_DIR      = 23;
    localparam int ITEM_BEATS = 1680;
    localparam int N_PHASES   = 6;
    localparam int MAX_GAP    = 12;
    localparam int SETTLE     = 6;
    localparam int DRAIN_MAX  = 2000;

    // how a directed row is checked
    typedef enum logic [1:0] {
        CHK_MODEL,
        CHK_GIVEN
    } row_check_t;

    typedef struct packed {
        mtfs_item_t   beat;
        row_check_t   chk;
        mtfs_result_t want;
    } dir_row_t;

    logic clk;
    logic rst_n;

    mtfs_byte_if   stream_if ();
    mtfs_result_if result_if ();
    mtfs_cfg_if    cfg_if ();

    modbus_tcp_frame_splitter uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .stream (stream_if),
        .result (result_if),
        .cfg    (cfg_if)
    );

    // deframer shadow state
    mtfs_phase_t        hdr_phase;
    logic [15:0]        frame_len;
    logic [31:0]        unframed_cnt;
    logic [15:0]        seg_offset;
    logic [7:0]         body_skip;
    bit                 dropping;
    bit                 len_bad;
    logic [LIMIT_W-1:0] limit_reg;

    mtfs_result_t due_results[$];
    dir_row_t     dir_rows[N_DIR];
    int           errors;
    int           item_beats;
    bit           src_idle;
    bit           snk_idle;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("Some tests failed");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t ns: %s", $time, msg);
        errors++;
    endtask

    function automatic void add_unframed(input logic [31:0] n);
        logic [32:0] sum;
        sum = {1'b0, unframed_cnt} + {1'b0, n};
        unframed_cnt = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
    endfunction

    // Advance the shadow deframer by one byte; returns 1 if the byte was a header byte.
    function automatic bit deframe_byte(input mtfs_item_t it, output bit has_res,
                                        output mtfs_result_t res);
        logic [15:0] offs;
        bit          parsed;
        bit          invalid;
        offs    = seg_offset;
        parsed  = 1'b0;
        invalid = 1'b0;
        has_res = 1'b0;
        res     = '0;
        res.status = ST_SEARCH;

        if (dropping)
        begin
            // rest of a rejected segment
        end
        else if (body_skip != 8'd0)
        begin
            body_skip = body_skip - 8'd1;
        end
        else
        begin
            parsed = 1'b1;
            case (hdr_phase)
                PH_LEN_HI:
                begin
                    frame_len = {it.data_byte, 8'h00};
                    hdr_phase = PH_LEN_LO;
                    add_unframed(32'd1);
                end
                PH_LEN_LO:
                begin
                    frame_len[7:0] = it.data_byte;
                    if (frame_len < 16'(LEN_MIN) || frame_len > 16'(LEN_MAX))
                    begin
                        len_bad = 1'b1;
                        invalid = 1'b1;
                    end
                    else
                    begin
                        hdr_phase = PH_UNIT;
                        add_unframed(32'd1);
                    end
                end
                PH_UNIT:
                begin
                    hdr_phase = PH_FUNC;
                    add_unframed(32'd1);
                end
                PH_FUNC:
                begin
                    if (it.data_byte == FC_NONE ||
                        (it.from_client && it.data_byte >= CLIENT_FC_LIMIT))
                    begin
                        invalid = 1'b1;
                    end
                    else
                    begin
                        res.status       = ST_FLUSH;
                        res.flush_offset = OFFS_W'(offs) + OFFS_W'(frame_len) - OFFS_W'(1);
                        body_skip        = 8'(frame_len - 16'd2);
                        unframed_cnt     = '0;
                        hdr_phase        = PH_TID_HI;
                        frame_len        = '0;
                        has_res          = 1'b1;
                    end
                end
                PH_TID_LO:
                begin
                    hdr_phase = PH_PID_HI;
                    add_unframed(32'd1);
                end
                PH_PID_HI:
                begin
                    hdr_phase = PH_PID_LO;
                    add_unframed(32'd1);
                end
                PH_PID_LO:
                begin
                    hdr_phase = PH_LEN_HI;
                    add_unframed(32'd1);
                end
                default:
                begin
                    hdr_phase = PH_TID_LO;
                    add_unframed(32'd1);
                end
            endcase
        end

        // rejected header: charge the rest of the segment, then drop it
        if (invalid)
        begin
            add_unframed(it.segment_length > offs ? 32'(it.segment_length - offs) : 32'd1);
            res.status       = (unframed_cnt >= 32'(limit_reg)) ? ST_ABORT : ST_SEARCH;
            res.flush_offset = '0;
            res.bad_length   = len_bad;
            len_bad          = 1'b0;
            hdr_phase        = PH_TID_HI;
            frame_len        = '0;
            if (!it.last_in_segment)
                dropping = 1'b1;
            has_res = 1'b1;
        end

        // segment ran out mid-header
        if (it.last_in_segment && parsed && !has_res)
            has_res = 1'b1;

        if (it.last_in_segment)
        begin
            seg_offset = '0;
            dropping   = 1'b0;
        end
        else
        begin
            seg_offset = offs + 16'd1;
        end
        return parsed;
    endfunction

    function automatic dir_row_t dir_row(input logic [7:0] b, input bit client,
                                         input logic [15:0] len, input bit last,
                                         input row_check_t chk, input mtfs_status_t st,
                                         input logic [OFFS_W-1:0] offs, input bit bad);
        dir_row_t r;
        r.beat.data_byte       = b;
        r.beat.from_client     = client;
        r.beat.segment_length  = len;
        r.beat.last_in_segment = last;
        r.chk                  = chk;
        r.want.status          = st;
        r.want.flush_offset    = offs;
        r.want.bad_length      = bad;
        return r;
    endfunction

    // One beat on the byte stream, with a random lead-in gap
    task automatic drive_beat(input mtfs_item_t it);
        int gap;
        if ($urandom_range(0, 47) == 0)
            src_idle = !src_idle;
        gap = src_idle ? int'($urandom_range(0, MAX_GAP)) : 0;
        if (gap > 0)
        begin
            stream_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        stream_if.valid           <= 1'b1;
        stream_if.data_byte       <= it.data_byte;
        stream_if.from_client     <= it.from_client;
        stream_if.segment_length  <= it.segment_length;
        stream_if.last_in_segment <= it.last_in_segment;
        do
            @(posedge clk);
        while (stream_if.ready !== 1'b1);
    endtask

    // Stop sending and let every expected result come out
    task automatic drain_results();
        stream_if.valid <= 1'b0;
        for (int w = 0; w < DRAIN_MAX && due_results.size() != 0; w++)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        if (due_results.size() != 0)
        begin
            report_mismatch($sformatf("%0d expected results never arrived",
                                      due_results.size()));
            due_results.delete();
        end
    endtask

    // A burst of frames in one direction, cut into segments at random points
    task automatic send_burst();
        logic [7:0]   bytes[$];
        bit           client;
        bit           hdr_ok;
        bit           has_res;
        int           sel;
        int           flen;
        int           seg;
        int           pos;
        logic [7:0]   fc;
        mtfs_item_t   it;
        mtfs_result_t res;

        client = 1'($urandom_range(0, 1));
        repeat ($urandom_range(1, 3))
        begin
            sel = int'($urandom_range(0, 99));
            // stray bytes ahead of the header
            if (sel < 5)
                repeat ($urandom_range(1, 6)) bytes.push_back(8'($urandom_range(0, 255)));
            bytes.push_back(8'($urandom_range(0, 255)));
            bytes.push_back(8'($urandom_range(0, 255)));
            bytes.push_back(sel < 80 ? 8'h00 : 8'($urandom_range(0, 255)));
            bytes.push_back(sel < 80 ? 8'h00 : 8'($urandom_range(0, 255)));

            sel = int'($urandom_range(0, 99));
            if (sel < 3)
                flen = int'($urandom_range(0, 1));
            else if (sel < 6)
                flen = int'($urandom_range(255, 65535));
            else if (sel < 16)
                flen = int'($urandom_range(2, 254));
            else
                flen = int'($urandom_range(2, 12));
            bytes.push_back(8'(flen >> 8));
            bytes.push_back(8'(flen));

            // occasionally the header is cut short
            if ($urandom_range(0, 19) != 0)
            begin
                bytes.push_back(8'($urandom_range(0, 255)));
                sel = int'($urandom_range(0, 99));
                if (sel < 4)
                    fc = FC_NONE;
                else if (sel < 9 && client)
                    fc = 8'($urandom_range(int'(CLIENT_FC_LIMIT), 255));
                else if (client)
                    fc = 8'($urandom_range(1, int'(CLIENT_FC_LIMIT) - 1));
                else
                    fc = 8'($urandom_range(1, 255));
                bytes.push_back(fc);
                hdr_ok = flen >= int'(LEN_MIN) && flen <= int'(LEN_MAX) && fc != FC_NONE &&
                         !(client && fc >= CLIENT_FC_LIMIT);
                if (hdr_ok)
                    repeat (flen - 2) bytes.push_back(8'($urandom_range(0, 255)));
            end
        end

        pos = 0;
        while (pos < bytes.size())
        begin
            if ($urandom_range(0, 3) == 0)
                seg = int'($urandom_range(1, bytes.size() - pos));
            else
                seg = bytes.size() - pos;
            it.from_client    = client;
            it.segment_length = ($urandom_range(0, 9) == 0) ?
                                16'($urandom_range(1, 65535)) : 16'(seg);
            for (int i = 0; i < seg; i++)
            begin
                it.data_byte       = bytes[pos + i];
                it.last_in_segment = (i == seg - 1);
                drive_beat(it);
                void'(deframe_byte(it, has_res, res));
                if (has_res)
                    due_results.push_back(res);
                item_beats++;
            end
            pos += seg;
        end
    endtask

    // Result sink with random stalls, checks each beat in order
    initial
    begin
        int           stall;
        mtfs_result_t want;
        result_if.ready <= 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 47) == 0)
                snk_idle = !snk_idle;
            stall = snk_idle ? int'($urandom_range(0, MAX_GAP)) : 0;
            if (stall > 0)
            begin
                result_if.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_if.ready <= 1'b1;
            do
                @(posedge clk);
            while (result_if.valid !== 1'b1);

            if (due_results.size() == 0)
            begin
                report_mismatch("result beat with none expected");
            end
            else
            begin
                want = due_results.pop_front();
                if (result_if.status !== want.status)
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              result_if.status, want.status));
                if (result_if.flush_offset !== want.flush_offset)
                    report_mismatch($sformatf("flush_offset %0d, expected %0d",
                                              result_if.flush_offset, want.flush_offset));
                if (result_if.bad_length !== want.bad_length)
                    report_mismatch($sformatf("bad_length %0b, expected %0b",
                                              result_if.bad_length, want.bad_length));
            end
        end
    end

    // Stimulus
    initial
    begin
        bit                 has_res;
        mtfs_result_t       res;
        logic [LIMIT_W-1:0] lim;

        rst_n                     <= 1'b0;
        stream_if.valid           <= 1'b0;
        stream_if.data_byte       <= '0;
        stream_if.from_client     <= 1'b0;
        stream_if.segment_length  <= '0;
        stream_if.last_in_segment <= 1'b0;
        cfg_if.valid              <= 1'b0;
        cfg_if.abort_limit        <= '0;

        errors       = 0;
        item_beats   = 0;
        src_idle     = 1'b0;
        snk_idle     = 1'b0;
        hdr_phase    = PH_TID_HI;
        frame_len    = '0;
        unframed_cnt = '0;
        seg_offset   = '0;
        body_skip    = '0;
        dropping     = 1'b0;
        len_bad      = 1'b0;
        limit_reg    = ABORT_LIMIT_RST;

        dir_rows = '{
            // server frame, length 2, all-ones bytes: flush just past the function code
            dir_row(8'hFF, 1'b0, 16'd8, 1'b0, CHK_MODEL, ST_SEARCH, '0, 1'b0),
            dir_row(8'hFF, 1'b0, 16'd8, 1'b0, CHK_MODEL, ST_SEARCH, '0, 1'b0),
            dir_row(8'hFF, 1'b0, 16'd8, 1'b0, CHK_MODEL, ST_SEARCH, '0, 1'b0),
            dir_row(8'hFF, 1'b0, 16'd8, 1'b0, CHK_MODEL, ST_SEARCH, '0, 1'b0),
            dir_row(8'h00, 1'b0, 16'd8, 1'b0, CHK_MODEL, ST_SEARCH, '0, 1'b0),
            dir_row(8'h02, 1'b0, 16'd8, 1'b0, CHK_MODEL, ST_SEARCH, '0, 1'b0),
            dir_row(8'hFF, 1'b0, 16'd8, 1'b0, CHK_MODEL, ST_SEARCH, '0, 1'b0),
            dir_row(8'hFF, 1'b0, 16'd8, 1'b1, CHK_GIVEN, ST_FLUSH, 17'd8, 1'b0),
            // one-byte segment ends mid-header
            dir_row(8'h00, 1'b1, 16'd1, 1'b1, CHK_GIVEN, ST_SEARCH, '0, 1'b0),
            // header continues, length 1 in a full-size segment reaches the limit
            dir_row(8'h00, 1'b1, 16'd65535, 1'b0, CHK_MODEL, ST_SEARCH, '0, 1'b0),
            dir_row(8'h00, 1'b1, 16'd65535, 1'b0, CHK_MODEL, ST_SEARCH, '0, 1'b0),
            dir_row(8'h00, 1'b1, 16'd65535, 1'b0, CHK_MODEL, ST_SEARCH, '0, 1'b0),
            dir_row(8'h00, 1'b1, 16'd65535, 1'b0, CHK_MODEL, ST_SEARCH, '0, 1'b0),
            dir_row(8'h01, 1'b1, 16'd65535, 1'b0, CHK_GIVEN, ST_ABORT, '0, 1'b1),
            // dropped byte at segment end gives nothing
            dir_row(8'hAB, 1'b1, 16'd65535, 1'b1, CHK_MODEL, ST_SEARCH, '0, 1'b0),
            // client function code 0x80 on the last byte; count stays above the limit
            dir_row(8'h12, 1'b1, 16'd8, 1'b0, CHK_MODEL, ST_SEARCH, '0, 1'b0),
            dir_row(8'h34, 1'b1, 16'd8, 1'b0, CHK_MODEL, ST_SEARCH, '0, 1'b0),
            dir_row(8'h00, 1'b1, 16'd8, 1'b0, CHK_MODEL, ST_SEARCH, '0, 1'b0),
            dir_row(8'h00, 1'b1, 16'd8, 1'b0, CHK_MODEL, ST_SEARCH, '0, 1'b0),
            dir_row(8'h00, 1'b1, 16'd8, 1'b0, CHK_MODEL, ST_SEARCH, '0, 1'b0),
            dir_row(8'hFE, 1'b1, 16'd8, 1'b0, CHK_MODEL, ST_SEARCH, '0, 1'b0),
            dir_row(8'h11, 1'b1, 16'd8, 1'b0, CHK_MODEL, ST_SEARCH, '0, 1'b0),
            dir_row(CLIENT_FC_LIMIT, 1'b1, 16'd8, 1'b1, CHK_GIVEN, ST_ABORT, '0, 1'b0)
        };

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows at the reset limit
        foreach (dir_rows[i])
        begin
            drive_beat(dir_rows[i].beat);
            void'(deframe_byte(dir_rows[i].beat, has_res, res));
            if (dir_rows[i].chk == CHK_GIVEN)
                due_results.push_back(dir_rows[i].want);
            else if (has_res)
                due_results.push_back(res);
        end

        // random bursts, one abort_limit setting per phase
        for (int p = 0; p < N_PHASES; p++)
        begin
            if (p > 0)
            begin
                drain_results();
                case (p)
                    1: lim = LIMIT_W'(1);
                    2: lim = '1;
                    3: lim = LIMIT_W'($urandom_range(2, 400));
                    4: lim = LIMIT_W'($urandom_range(1, 24'hFF_FFFF));
                    default: lim = ABORT_LIMIT_RST;
                endcase
                cfg_if.valid       <= 1'b1;
                cfg_if.abort_limit <= lim;
                do
                    @(posedge clk);
                while (cfg_if.ready !== 1'b1);
                cfg_if.valid <= 1'b0;
                limit_reg = lim;
            end
            item_beats = 0;
            while (item_beats < ITEM_BEATS / N_PHASES)
                send_burst();
        end

        drain_results();
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
